### hdl/fqt_pkg.sv
// Shared types and constants for the Frugal-2U quantile tracker.
// Used by every module of the tracker. Depends on nothing.
`default_nettype none

package fqt_pkg;

    // Reset value of the target quantile (about 0.99 at a 16-bit fraction).
    localparam logic [31:0] QUANTILE_RESET = 32'd64880;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Outcome of the random gates, decided in the front when a request is taken.
    typedef struct packed {
        logic up_ok;
        logic down_ok;
    } gate_t;

    localparam int GATE_W = $bits(gate_t);

endpackage

`default_nettype wire

### hdl/fqt_front.sv
// Front end: holds the quantile register and classifies each request by
// its random draw. Depends on fqt_pkg.
`default_nettype none

module fqt_front #(
    parameter int DRAW_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [DRAW_WIDTH-1:0] cfg_data,
    input  wire logic [DRAW_WIDTH-1:0] random_draw,
    output fqt_pkg::gate_t             gate
);

    logic [DRAW_WIDTH-1:0] quant_reg;
    logic [DRAW_WIDTH-1:0] quant_next;
    logic [DRAW_WIDTH:0]   up_limit;

    always_comb
    begin
        quant_next = cfg_valid ? cfg_data : quant_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_reg <= fqt_pkg::QUANTILE_RESET[DRAW_WIDTH-1:0];
        end
        else
        begin
            quant_reg <= quant_next;
        end
    end

    // An upward move needs draw > 2^DRAW_WIDTH - q, so one extra bit is kept.
    assign up_limit     = {1'b1, {DRAW_WIDTH{1'b0}}} - {1'b0, quant_reg};
    assign gate.up_ok   = ({1'b0, random_draw} > up_limit);
    assign gate.down_ok = (random_draw > quant_reg);

endmodule

`default_nettype wire

### hdl/fqt_queue.sv
// Short queue that decouples the classifying front from the updating back.
// Depends on fqt_pkg for its depth.
`default_nettype none

module fqt_queue #(
    parameter int DATA_WIDTH = 34
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    output logic                       full,
    output logic                       not_empty,
    input  wire logic                  pop,
    output logic [DATA_WIDTH-1:0]      head_data
);

    logic [DATA_WIDTH-1:0]           mem [fqt_pkg::QUEUE_DEPTH];
    logic [fqt_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [fqt_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [fqt_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [fqt_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [fqt_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [fqt_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [fqt_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        fqt_pkg::QUEUE_PTR_W'(fqt_pkg::QUEUE_DEPTH - 1);
    localparam logic [fqt_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        fqt_pkg::QUEUE_CNT_W'(fqt_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/fqt_back.sv
// Back end: applies the Frugal-2U update to the estimate state and holds
// the result register. Depends on fqt_pkg for the gate type.
`default_nettype none

module fqt_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic signed [VALUE_WIDTH-1:0] req_item,
    input  wire fqt_pkg::gate_t                req_gate,
    output logic                               req_take,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0]      estimate_value,
    output logic signed [VALUE_WIDTH-1:0]      step_value
);

    localparam logic signed [VALUE_WIDTH-1:0] ZERO = '0;
    localparam logic signed [VALUE_WIDTH-1:0] ONE  = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

    logic signed [VALUE_WIDTH-1:0] est_reg;
    logic signed [VALUE_WIDTH-1:0] est_next;
    logic signed [VALUE_WIDTH-1:0] step_reg;
    logic signed [VALUE_WIDTH-1:0] step_next;
    logic                          dir_up_reg;
    logic                          dir_up_next;
    logic                          started_reg;
    logic                          started_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_est_reg;
    logic signed [VALUE_WIDTH-1:0] out_step_reg;

    logic                          move_up;
    logic                          move_down;
    logic signed [VALUE_WIDTH-1:0] step_a;
    logic signed [VALUE_WIDTH-1:0] stride;
    logic signed [VALUE_WIDTH-1:0] est_a;
    logic                          overshoot;
    logic signed [VALUE_WIDTH-1:0] step_b;
    logic signed [VALUE_WIDTH-1:0] est_b;
    logic                          far;
    logic                          load;

    // The result register is free when empty or being taken this cycle.
    assign req_take = !out_valid_reg || !out_stall;
    assign load     = req_take && req_valid;

    always_comb
    begin
        move_up   = (est_reg < req_item) && req_gate.up_ok;
        move_down = (req_item < est_reg) && req_gate.down_ok;

        // The step grows when the move keeps the last direction.
        step_a = (dir_up_reg == move_up) ? step_reg + ONE : step_reg - ONE;
        stride = (step_a > ZERO) ? step_a : ONE;
        est_a  = move_up ? est_reg + stride : est_reg - stride;

        // Overshooting the item clamps the estimate and gives back the excess.
        overshoot = move_up ? (req_item < est_a) : (est_a < req_item);
        if (overshoot)
        begin
            step_b = move_up ? step_a + req_item - est_a : step_a + est_a - req_item;
            est_b  = req_item;
        end
        else
        begin
            step_b = step_a;
            est_b  = est_a;
        end

        est_next     = est_reg;
        step_next    = step_reg;
        dir_up_next  = dir_up_reg;
        started_next = started_reg;
        far          = 1'b0;
        if (load)
        begin
            if (!started_reg)
            begin
                est_next     = req_item;
                started_next = 1'b1;
            end
            else
            begin
                if (move_up || move_down)
                begin
                    est_next    = est_b;
                    step_next   = step_b;
                    dir_up_next = move_up;
                end
                far = dir_up_next ? (est_next < req_item) : (req_item < est_next);
                if (far && (step_next > ONE))
                begin
                    step_next = ONE;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg       <= ZERO;
            step_reg      <= ONE;
            dir_up_reg    <= 1'b1;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            est_reg       <= est_next;
            step_reg      <= step_next;
            dir_up_reg    <= dir_up_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_est_reg  <= est_next;
            out_step_reg <= step_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign estimate_value = out_est_reg;
    assign step_value     = out_step_reg;

endmodule

`default_nettype wire

### hdl/frugal_two_unit_quantile_tracker_core.sv
// Top level of the Frugal-2U streaming quantile tracker.
// Depends on fqt_pkg, fqt_front, fqt_queue and fqt_back.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_stall    item_value, random_draw
//  output    out_valid / out_stall  estimate_value, step_value
//  config    cfg_valid / cfg_ready  quantile_fraction
//
// One request is accepted per cycle while in_stall is low; each request waits
// in the queue, then passes through the update stage into its result register.
// Throughput is set by the combinational compare-add update of the back end.
// A stalled output fills the two-entry queue, after which in_stall rises.
// Reset is asynchronous and needs no clearing pass; cfg_ready is always high.
`default_nettype none

module frugal_two_unit_quantile_tracker_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int DRAW_WIDTH  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] item_value,
    input  wire logic [DRAW_WIDTH-1:0]         random_draw,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0]      estimate_value,
    output logic signed [VALUE_WIDTH-1:0]      step_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [DRAW_WIDTH-1:0]         quantile_fraction
);

    localparam int ENTRY_W = VALUE_WIDTH + fqt_pkg::GATE_W;

    fqt_pkg::gate_t                in_gate;
    fqt_pkg::gate_t                head_gate;
    logic                          q_full;
    logic                          q_not_empty;
    logic                          q_pop;
    logic [ENTRY_W-1:0]            head_data;
    logic signed [VALUE_WIDTH-1:0] head_item;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    fqt_front #(
        .DRAW_WIDTH (DRAW_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_data    (quantile_fraction),
        .random_draw (random_draw),
        .gate        (in_gate)
    );

    fqt_queue #(
        .DATA_WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data ({item_value, in_gate}),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head_data (head_data)
    );

    assign head_item = head_data[ENTRY_W-1:fqt_pkg::GATE_W];
    assign head_gate = head_data[fqt_pkg::GATE_W-1:0];

    fqt_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (q_not_empty),
        .req_item       (head_item),
        .req_gate       (head_gate),
        .req_take       (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .estimate_value (estimate_value),
        .step_value     (step_value)
    );

endmodule

`default_nettype wire

### hdl/fqt_checker.sv
// Port-level checks for the quantile tracker, bound to its top level.
// Depends only on the ports of frugal_two_unit_quantile_tracker_core.
`default_nettype none

module fqt_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [VALUE_WIDTH-1:0] estimate_value,
    input wire logic [VALUE_WIDTH-1:0] step_value,
    input wire logic                   cfg_ready
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(estimate_value) && $stable(step_value))
        else $error("result payload changed while stalled");

    // The quantile register takes a write in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

    // No result can be offered straight out of reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

    // With the output held stalled and the input refused, nothing new can
    // have entered, so the input side stays stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && out_valid && out_stall |=> in_stall || !out_stall || !$past(out_stall))
        else $error("input freed while the pipeline was blocked");

endmodule

bind frugal_two_unit_quantile_tracker_core fqt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_fqt_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the Frugal-2U streaming quantile tracker core.
// Needs fqt_pkg and the RTL of frugal_two_unit_quantile_tracker_core only.
// A directed table, then random requests checked against a built-in tracker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = 32;
    localparam int DW          = 16;
    localparam int SETTLE      = 4;
    localparam int QUIET_LIMIT = 1000;
    localparam int PLAN_ROWS   = 21;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic signed [VW-1:0] est;
        logic signed [VW-1:0] step;
    } tracker_out_t;

    // One directed request: item is an offset from the current estimate when rel is set.
    typedef struct packed {
        bit                   rel;
        logic signed [VW-1:0] item;
        logic [DW-1:0]        draw;
        bit                   known;
        logic signed [VW-1:0] est;
        logic signed [VW-1:0] step;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [VW-1:0] item_value = '0;
    logic [DW-1:0]        random_draw = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [VW-1:0] estimate_value;
    logic signed [VW-1:0] step_value;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DW-1:0]        quantile_fraction = '0;

    // Tracker state as the block should hold it.
    logic signed [VW-1:0] track_est = '0;
    logic signed [VW-1:0] track_step = 32'sd1;
    bit                   track_rising = 1'b1;
    bit                   track_loaded = 1'b0;
    logic [DW-1:0]        track_quantile = fqt_pkg::QUANTILE_RESET[DW-1:0];

    tracker_out_t pending_results[$];
    int           errors = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           cfg_writes = 0;
    int           quiet_cycles = 0;
    bit           calm = 1'b0;

    frugal_two_unit_quantile_tracker_core #(
        .VALUE_WIDTH(VW),
        .DRAW_WIDTH (DW)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .item_value       (item_value),
        .random_draw      (random_draw),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .estimate_value   (estimate_value),
        .step_value       (step_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .quantile_fraction(quantile_fraction)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one item to the tracker state and returns the estimate and step after it.
    function automatic tracker_out_t track_item(logic signed [VW-1:0] item,
                                                logic [DW-1:0] draw);
        logic [DW:0]  up_bar;
        tracker_out_t res;
        up_bar = (17'd1 << DW) - {1'b0, track_quantile};
        if (!track_loaded)
        begin
            track_loaded = 1'b1;
            track_est = item;
        end
        else
        begin
            if (track_est < item && {1'b0, draw} > up_bar)
            begin
                track_step = track_rising ? track_step + 32'sd1 : track_step - 32'sd1;
                track_est = track_est + ((track_step > 32'sd0) ? track_step : 32'sd1);
                track_rising = 1'b1;
                if (item < track_est)
                begin
                    track_step = track_step + item - track_est;
                    track_est = item;
                end
            end
            else if (item < track_est && draw > track_quantile)
            begin
                track_step = !track_rising ? track_step + 32'sd1 : track_step - 32'sd1;
                track_est = track_est - ((track_step > 32'sd0) ? track_step : 32'sd1);
                track_rising = 1'b0;
                if (track_est < item)
                begin
                    track_step = track_step + track_est - item;
                    track_est = item;
                end
            end
            // Still short of the item in the current direction: the step falls back to one.
            if ((track_rising ? track_est < item : item < track_est) && track_step > 32'sd1)
                track_step = 32'sd1;
        end
        res.est = track_est;
        res.step = track_step;
        return res;
    endfunction

    task automatic offer_item(input logic signed [VW-1:0] item, input logic [DW-1:0] draw,
                              input bit known, input tracker_out_t typed);
        tracker_out_t pred;
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        item_value <= item;
        random_draw <= draw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = track_item(item, draw);
        pending_results.push_back(known ? typed : pred);
        items_sent++;
    endtask

    // The quantile register is only written once the tracker has gone idle.
    task automatic set_quantile(input logic [DW-1:0] q);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        quantile_fraction <= q;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        track_quantile = q;
        cfg_writes++;
    endtask

    initial
    begin : result_side
        int           hold_left;
        bit           held;
        tracker_out_t want;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result estimate %0d step %0d",
                             $time, estimate_value, step_value);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (estimate_value !== want.est)
                    begin
                        $display("%0t: estimate expected %0d got %0d",
                                 $time, want.est, estimate_value);
                        errors++;
                    end
                    if (step_value !== want.step)
                    begin
                        $display("%0t: step expected %0d got %0d",
                                 $time, want.step, step_value);
                        errors++;
                    end
                end
            end
            // A long hold-off while requests keep coming, so the queue fills up.
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && $urandom_range(0, 99) < 9;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        plan_row_t            plan [PLAN_ROWS];
        logic [DW-1:0]        q_list [PHASES];
        logic signed [VW-1:0] item;
        logic [DW-1:0]        draw;
        tracker_out_t         typed;
        int                   pick;
        int                   bar;

        // With the reset quantile an upward move needs a draw above 656,
        // a downward move a draw above 64880.
        plan = '{
            '{1'b0, 32'sd100,       16'd0,     1'b1, 32'sd100, 32'sd1}, // first item loads
            '{1'b0, 32'sd200,       16'd656,   1'b1, 32'sd100, 32'sd1}, // draw equals the bar
            '{1'b0, 32'sd100,       16'd65535, 1'b1, 32'sd100, 32'sd1}, // item equals estimate
            '{1'b1, 32'sd1,         16'd65535, 1'b0, 32'sd0,   32'sd0}, // overshoot clamps
            '{1'b1, 32'sd1,         16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b1, 32'sd50,        16'd657,   1'b0, 32'sd0,   32'sd0},
            '{1'b1, -32'sd1,        16'd65535, 1'b0, 32'sd0,   32'sd0}, // reversal
            '{1'b1, -32'sd1,        16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b1, -32'sd1,        16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b1, -32'sd20,       16'd64881, 1'b0, 32'sd0,   32'sd0},
            '{1'b1, -32'sd20,       16'd64880, 1'b0, 32'sd0,   32'sd0},
            '{1'b1, 32'sd3,         16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'h7fff_ffff,  16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'h7fff_ffff,  16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'h8000_0000,  16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'h8000_0000,  16'd0,     1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'h5555_5555,  16'haaaa,  1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'haaaa_aaaa,  16'h5555,  1'b0, 32'sd0,   32'sd0},
            '{1'b1, 32'sd0,         16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b0, -32'sd1,        16'd65535, 1'b0, 32'sd0,   32'sd0},
            '{1'b0, 32'sd0,         16'd1,     1'b0, 32'sd0,   32'sd0}
        };
        q_list = '{16'd0, 16'd65535, 16'd32768, 16'd1, DW'($urandom), DW'($urandom),
                   fqt_pkg::QUANTILE_RESET[DW-1:0]};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            item = plan[i].rel ? track_est + plan[i].item : plan[i].item;
            typed.est = plan[i].est;
            typed.step = plan[i].step;
            offer_item(item, plan[i].draw, plan[i].known, typed);
        end
        in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_quantile(q_list[p]);
            calm = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Mostly items close to the estimate, where the step rules matter.
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    item = track_est + (int'($urandom_range(0, 40)) - 20);
                else if (pick < 65)
                    item = track_est;
                else if (pick < 85)
                    item = $urandom;
                else if (pick < 90)
                    item = 32'h7fff_ffff;
                else if (pick < 95)
                    item = 32'h8000_0000;
                else
                    item = track_est + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
                if ($urandom_range(0, 99) < 65)
                    draw = DW'($urandom_range(0, 65535));
                else
                begin
                    bar = $urandom_range(0, 1) ? 65536 - int'(track_quantile)
                                               : int'(track_quantile);
                    bar = bar + int'($urandom_range(0, 2)) - 1;
                    if (bar < 0)
                        bar = 0;
                    if (bar > 65535)
                        bar = 65535;
                    draw = DW'(bar);
                end
                typed = '0;
                offer_item(item, draw, 1'b0, typed);
            end
            in_valid <= 1'b0;
            calm = 1'b0;
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);

        $display("Ran %0d requests and checked %0d results over %0d quantile writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with the first-item load, clamps, reversals, extremes and a long hold-off.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
